// ===== rtl/wls_pkg.sv =====
// Shared constants and types of the leftmost wildcard search block.
// Used by the request/result interfaces and by every module of the block.
package wls_pkg;

  localparam int unsigned     MAX_PATTERN_DEF  = 64;
  localparam longint unsigned MAX_TEXT_LEN_DEF = 64'd65535;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned POS_W = 16;

  localparam logic [SYM_W-1:0] SYM_ANY   = 8'd63;
  localparam logic [SYM_W-1:0] SYM_STAR  = 8'd42;
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_PATTERN = 2'd0,
    OP_TEXT    = 2'd1,
    OP_REPORT  = 2'd2
  } op_e;

  // Request held in the input register; valid marks a request that is executed.
  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [SYM_W-1:0] sym;
  } cmd_t;

  // Result of a report request.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             too_long;
  } res_t;

endpackage

// ===== rtl/wls_if.sv =====
// Request and result channels of the leftmost wildcard search block.
// Depends on wls_pkg for the field widths.
interface wls_req_if;
  import wls_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, operation, symbol, input ready);
  modport sink   (input valid, operation, symbol, output ready);
endinterface

interface wls_rsp_if;
  import wls_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             too_long;

  modport source (output valid, found, position, too_long, input ready);
  modport sink   (input valid, found, position, too_long, output ready);
endinterface

// ===== rtl/wls_in_stage.sv =====
// Input register of the leftmost wildcard search block.
// Depends on wls_pkg and on the request interface in wls_if.sv.
module wls_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  wls_req_if.sink        req_i,
  input  logic           adv_i,
  output wls_pkg::cmd_t  cmd_o
);
  import wls_pkg::*;

  logic             valid_q;
  op_e              op_q;
  logic [SYM_W-1:0] sym_q;
  logic             load;

  // The register frees up whenever the held request is executed this cycle.
  assign req_i.ready = !valid_q || adv_i;
  assign load        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q  <= op_e'(req_i.operation);
      sym_q <= req_i.symbol;
    end
  end

  assign cmd_o = '{valid: valid_q, op: op_q, sym: sym_q};

endmodule

// ===== rtl/wls_nfa.sv =====
// Pattern store, NFA cell array and match bookkeeping of the wildcard search.
// Depends on wls_pkg.
module wls_nfa #(
  parameter int unsigned     MAX_PATTERN  = wls_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT_LEN = wls_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wls_pkg::cmd_t  cmd_i,
  output wls_pkg::res_t  res_o
);
  import wls_pkg::*;

  localparam int unsigned NC = MAX_PATTERN + 1;
  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned TW = $clog2(MAX_TEXT_LEN + 1);
  localparam int unsigned LV = $clog2(NC);

  typedef struct packed {
    logic          act;
    logic [TW-1:0] start;
  } thr_t;

  function automatic thr_t tmin(thr_t a, thr_t b);
    thr_t r;
    if (!a.act) begin
      r = b;
    end else if (!b.act) begin
      r = a;
    end else if (b.start < a.start) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

  // Pattern store.
  logic [SYM_W-1:0] sym_q   [MAX_PATTERN];
  logic             astar_q [MAX_PATTERN];
  logic [CW-1:0]    pcnt_q;
  logic             star_seen_q;

  // Thread state per cell, kept as it stands after a byte is consumed.
  logic [NC-1:0]    act_q;
  logic [TW-1:0]    st_q [NC];

  logic [TW-1:0]    tcnt_q;
  thr_t             best_q;
  logic             ovf_q;

  logic [NC-1:0]    in_pat, is_star, link, patch;
  thr_t             cur [NC];
  thr_t             hv  [NC];
  thr_t             clo [NC];
  thr_t             nxt [NC];
  thr_t             seg_g [LV+1][NC];
  logic             seg_f [LV+1][NC];
  thr_t             acc_thr, best_new;
  logic             c_space, sym_is_star;
  logic             pat_wr, txt_go, rpt, ovf_set;

  assign c_space     = (cmd_i.sym == SYM_SPACE);
  assign sym_is_star = (cmd_i.sym == SYM_STAR);

  always_comb begin
    pat_wr  = 1'b0;
    txt_go  = 1'b0;
    rpt     = 1'b0;
    ovf_set = 1'b0;
    if (cmd_i.valid) begin
      unique case (cmd_i.op)
        OP_PATTERN: begin
          pat_wr  = (pcnt_q < CW'(MAX_PATTERN));
          ovf_set = !pat_wr;
        end
        OP_TEXT: begin
          txt_go  = (tcnt_q < TW'(MAX_TEXT_LEN));
          ovf_set = !txt_go;
        end
        OP_REPORT: begin
          rpt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Cells that are joined by a star form a segment. The stored values inside
  // a segment never grow along it, so the closure needs only the value of the
  // segment head, spread over the segment by a log-depth copy network.
  for (genvar j = 0; j < NC; j++) begin : g_cell
    assign in_pat[j] = (CW'(j) < pcnt_q);
    if (j < MAX_PATTERN) begin : g_sym
      assign is_star[j] = in_pat[j] && (sym_q[j] == SYM_STAR);
    end else begin : g_nosym
      assign is_star[j] = 1'b0;
    end

    assign cur[j] = '{act: act_q[j], start: st_q[j]};

    if (j == 0) begin : g_head0
      assign link[0]  = 1'b0;
      assign patch[0] = 1'b0;
      // Unless an older thread holds it, a new one starts here, behind all older ones.
      assign hv[0]    = act_q[0] ? cur[0] : thr_t'{act: 1'b1, start: tcnt_q};
      assign clo[0]   = hv[0];
      assign nxt[0]   = (is_star[0] && clo[0].act && !c_space) ? clo[0] : '0;
    end else begin : g_body
      logic lit_ok, adv_ok;
      thr_t self_v, adv_v;

      assign link[j]  = is_star[j-1];
      assign hv[j]    = cur[j];
      // A star appended behind a star turns the segment tail into an inner
      // cell; it takes its neighbor's value so the ordering along the
      // segment holds.
      assign patch[j] = pat_wr && sym_is_star && (pcnt_q == CW'(j)) && link[j];

      assign clo[j] = !link[j]   ? hv[j] :
                      is_star[j] ? tmin(seg_g[LV][j], cur[j]) :
                                   tmin(seg_g[LV][j], cur[j-1]);

      assign lit_ok = (sym_q[j-1] == SYM_ANY) ? !c_space :
                      ((sym_q[j-1] == cmd_i.sym) && !(astar_q[j-1] && c_space));
      assign adv_ok = in_pat[j-1] && !is_star[j-1] && clo[j-1].act && lit_ok;
      assign self_v = (is_star[j] && clo[j].act && !c_space) ? clo[j] : '0;
      assign adv_v  = adv_ok ? clo[j-1] : '0;
      assign nxt[j] = tmin(self_v, adv_v);
    end

    assign seg_g[0][j] = hv[j];
    assign seg_f[0][j] = link[j];
  end

  for (genvar l = 0; l < LV; l++) begin : g_lvl
    localparam int unsigned D = 1 << l;
    for (genvar j = 0; j < NC; j++) begin : g_node
      if (j >= D) begin : g_hop
        assign seg_g[l+1][j] = seg_f[l][j] ? seg_g[l][j-D] : seg_g[l][j];
        assign seg_f[l+1][j] = seg_f[l][j] & seg_f[l][j-D];
      end else begin : g_pass
        assign seg_g[l+1][j] = seg_g[l][j];
        assign seg_f[l+1][j] = seg_f[l][j];
      end
    end
  end

  // The cell at the pattern length holds the earliest complete match.
  always_comb begin
    acc_thr = '0;
    for (int j = 0; j < NC; j++) begin
      if (pcnt_q == CW'(j)) begin
        acc_thr = clo[j];
      end
    end
  end

  assign best_new = (pcnt_q != '0) ? tmin(best_q, acc_thr) : best_q;

  always_comb begin
    res_o.too_long = ovf_q;
    if (pcnt_q == '0) begin
      res_o.found    = 1'b1;
      res_o.position = POS_W'(tcnt_q);
    end else begin
      res_o.found    = best_new.act;
      res_o.position = best_new.act ? POS_W'(best_new.start) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_wr) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (pcnt_q == CW'(i)) begin
          sym_q[i]   <= cmd_i.sym;
          astar_q[i] <= star_seen_q;
        end
      end
    end
  end

  for (genvar j = 0; j < NC; j++) begin : g_thr
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        act_q[j] <= 1'b0;
      end else if (rpt) begin
        act_q[j] <= 1'b0;
      end else if (txt_go) begin
        act_q[j] <= nxt[j].act;
      end else if (patch[j]) begin
        act_q[j] <= act_q[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (txt_go) begin
        st_q[j] <= nxt[j].start;
      end else if (patch[j]) begin
        st_q[j] <= st_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q      <= '0;
      star_seen_q <= 1'b0;
      tcnt_q      <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
    end else if (rpt) begin
      pcnt_q      <= '0;
      star_seen_q <= 1'b0;
      tcnt_q      <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (pat_wr) begin
        pcnt_q <= pcnt_q + CW'(1);
        if (sym_is_star) begin
          star_seen_q <= 1'b1;
        end
      end
      if (txt_go) begin
        tcnt_q <= tcnt_q + TW'(1);
        best_q <= best_new;
      end
      if (ovf_set) begin
        ovf_q <= 1'b1;
      end
    end
  end

  // No thread ever sits past the end of the loaded pattern.
  for (genvar j = 0; j < NC; j++) begin : g_chk_tail
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (CW'(j) > pcnt_q) |-> !act_q[j])
      else $error("thread active beyond the pattern end");
  end

  // Inside a star run, a live cell implies a live right neighbor that
  // started no later; the head-only closure depends on it.
  for (genvar j = 1; j + 1 < NC; j++) begin : g_chk_order
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (link[j] && is_star[j] && is_star[j+1] && act_q[j])
        |-> (act_q[j+1] && (st_q[j+1] <= st_q[j])))
      else $error("start order broken inside a star run");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(ovf_set))
    else $error("overflow flag set without a dropped request");

endmodule

// ===== rtl/wildcard_leftmost_search.sv =====
// Top level of the leftmost wildcard search block.
// Depends on wls_pkg, wls_if.sv, wls_in_stage and wls_nfa.

// Each request is one pattern symbol, one text byte, or an end-of-text report.
// Pattern symbols are appended in order ('?' takes one non-space byte, '*' a
// run of zero or more non-space bytes, and after the first '*' nothing takes
// a space); text bytes then advance all pattern cells at once, and a report
// returns the leftmost start at which the pattern matches the text that
// follows it, then clears pattern, text and flags for the next search. Only
// a report produces a result. The block takes one request per clock cycle,
// whatever its kind, because every cell of the match array updates in
// parallel from the registered request. A report passes from the input
// register to the result register, which drives the result port; a report
// stalls in the input register only while the result register still holds
// an earlier report that has not been taken, and other requests keep flowing
// past a waiting result. Up to MAX_PATTERN symbols and MAX_TEXT_LEN bytes
// are kept; any beyond that are dropped and the report raises too_long. An
// empty pattern reports the text length as a match. Position carries the
// low 16 bits of the start index.
module wildcard_leftmost_search #(
  parameter int unsigned     MAX_PATTERN  = wls_pkg::MAX_PATTERN_DEF,
  parameter longint unsigned MAX_TEXT_LEN = wls_pkg::MAX_TEXT_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wls_req_if.sink    req_i,
  wls_rsp_if.source  rsp_o
);
  import wls_pkg::*;

  cmd_t cmd_q;
  cmd_t cmd_fire;
  res_t res;
  res_t rsp_q;
  logic rsp_valid_q;
  logic adv;
  logic rpt_fire;

  // The held request executes now unless it is a report that has nowhere
  // to go because the result register is full and not being drained.
  assign adv = (cmd_q.op != OP_REPORT) || !rsp_valid_q || rsp_o.ready;

  wls_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .adv_i  (adv),
    .cmd_o  (cmd_q)
  );

  assign cmd_fire = '{valid: cmd_q.valid && adv, op: cmd_q.op, sym: cmd_q.sym};
  assign rpt_fire = cmd_fire.valid && (cmd_q.op == OP_REPORT);

  wls_nfa #(
    .MAX_PATTERN  (MAX_PATTERN),
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_nfa (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_fire),
    .res_o  (res)
  );

  // Result register: a new report may overwrite a result that is being taken
  // in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rpt_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpt_fire) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = rsp_q.found;
  assign rsp_o.position = rsp_q.position;
  assign rsp_o.too_long = rsp_q.too_long;

  // The request side only stalls behind a report blocked by an undrained result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (cmd_q.valid && (cmd_q.op == OP_REPORT) &&
                      rsp_valid_q && !rsp_o.ready))
    else $error("request side stalled without a blocked report");

  // Every executed report shows up on the result port in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_fire |=> rsp_o.valid)
    else $error("executed report produced no result");

endmodule
